>>> hw/rtl/rhsv_pkg.sv
package rhsv_pkg;

   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned HUE_W       = 16;
   localparam int unsigned SAT_W       = 16;
   localparam int unsigned SAT_NUM_W   = 24;
   localparam int unsigned HUE_DIV_W   = 11;
   localparam int unsigned DIV_STEPS   = 16;
   // power of two, pointers wrap on their own
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   // classified request, front to back
   typedef struct packed {
      logic [CHAN_W-1:0]    value;
      logic                 undef;
      logic                 chroma;
      logic [SAT_NUM_W-1:0] sat_num;
      logic [HUE_DIV_W-1:0] hue_x;
      logic [HUE_DIV_W-1:0] hue_div;
   } rhsv_work_type;

endpackage

>>> hw/rtl/rhsv_if.sv
interface rhsv_req_if;
   import rhsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface rhsv_rsp_if;
   import rhsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [SAT_W-1:0]  saturation;
   logic [CHAN_W-1:0] value;
   logic              hue_undefined;
   modport source (output valid, hue, saturation, value, hue_undefined, input ready);
   modport sink (input valid, hue, saturation, value, hue_undefined, output ready);
endinterface

>>> hw/rtl/rhsv_front.sv
module rhsv_front (
   input  logic                   clock,
   input  logic                   reset,
   rhsv_req_if.sink               req_bus,
   output logic                   work_valid,
   input  logic                   work_ready,
   output rhsv_pkg::rhsv_work_type work_data
);
   import rhsv_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   rhsv_work_type        data_ff;
   rhsv_work_type        data_in;
   logic [CHAN_W-1:0]    mx;
   logic [CHAN_W-1:0]    mn;
   logic [CHAN_W-1:0]    delta;
   logic [12:0]          d6;
   logic signed [12:0]   x_raw;
   logic signed [12:0]   x_wrap;

   always_comb begin
      mx = (req_bus.red > req_bus.green) ? req_bus.red : req_bus.green;
      mx = (mx > req_bus.blue) ? mx : req_bus.blue;
      mn = (req_bus.red < req_bus.green) ? req_bus.red : req_bus.green;
      mn = (mn < req_bus.blue) ? mn : req_bus.blue;
      delta = mx - mn;
      d6 = ({5'b0, delta} << 2) + ({5'b0, delta} << 1);

      // sector priority: red, green, blue
      priority if (req_bus.red == mx) begin
         x_raw = $signed({5'b0, req_bus.green}) - $signed({5'b0, req_bus.blue});
      end else if (req_bus.green == mx) begin
         x_raw = $signed({4'b0, delta, 1'b0}) + $signed({5'b0, req_bus.blue})
                 - $signed({5'b0, req_bus.red});
      end else begin
         x_raw = $signed({3'b0, delta, 2'b0}) + $signed({5'b0, req_bus.red})
                 - $signed({5'b0, req_bus.green});
      end
      x_wrap = (x_raw < 0) ? (x_raw + $signed(d6)) : x_raw;

      data_in.value   = mx;
      data_in.undef   = (mx == '0);
      data_in.chroma  = (delta != '0);
      data_in.sat_num = {delta, 16'b0} - {16'b0, delta};
      data_in.hue_x   = x_wrap[HUE_DIV_W-1:0];
      data_in.hue_div = d6[HUE_DIV_W-1:0];
   end

   assign req_bus.ready = !valid_ff || work_ready;
   assign valid_in      = req_bus.ready ? req_bus.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_bus.ready && req_bus.valid) begin
         data_ff <= data_in;
      end
   end

   assign work_valid = valid_ff;
   assign work_data  = data_ff;

endmodule

>>> hw/rtl/rhsv_queue.sv
module rhsv_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  rhsv_pkg::rhsv_work_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output rhsv_pkg::rhsv_work_type pop_data
);
   import rhsv_pkg::*;

   rhsv_work_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/rhsv_back.sv
module rhsv_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    work_valid,
   output logic                    work_ready,
   input  rhsv_pkg::rhsv_work_type work_data,
   rhsv_rsp_if.source              rsp_bus
);
   import rhsv_pkg::*;

   // two restoring dividers side by side, one quotient bit per stage
   typedef struct packed {
      logic [CHAN_W-1:0]    value;
      logic                 undef;
      logic                 chroma;
      logic [CHAN_W-1:0]    sat_rem;
      logic [SAT_W-1:0]     sat_bits;
      logic [SAT_W-1:0]     sat_q;
      logic [HUE_DIV_W-1:0] hue_rem;
      logic [HUE_DIV_W-1:0] hue_div;
      logic [HUE_W-1:0]     hue_q;
   } rhsv_stage_type;

   logic [DIV_STEPS:0] vld_ff;
   logic [DIV_STEPS:0] vld_in;
   rhsv_stage_type     stg_ff [DIV_STEPS+1];
   rhsv_stage_type     stg_in [DIV_STEPS+1];
   logic               advance;
   rhsv_stage_type     last;

   assign advance    = !vld_ff[DIV_STEPS] || rsp_bus.ready;
   assign work_ready = advance;

   always_comb begin
      vld_in[0]          = work_valid;
      stg_in[0].value    = work_data.value;
      stg_in[0].undef    = work_data.undef;
      stg_in[0].chroma   = work_data.chroma;
      stg_in[0].sat_rem  = work_data.sat_num[SAT_NUM_W-1:SAT_W];
      stg_in[0].sat_bits = work_data.sat_num[SAT_W-1:0];
      stg_in[0].sat_q    = '0;
      stg_in[0].hue_rem  = work_data.hue_x;
      stg_in[0].hue_div  = work_data.hue_div;
      stg_in[0].hue_q    = '0;
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      logic [CHAN_W:0]    sat_t;
      logic [HUE_DIV_W:0] hue_t;
      logic               sat_qb;
      logic               hue_qb;

      always_comb begin
         sat_t  = {stg_ff[s-1].sat_rem, stg_ff[s-1].sat_bits[SAT_W-1]};
         hue_t  = {stg_ff[s-1].hue_rem, 1'b0};
         sat_qb = (sat_t >= {1'b0, stg_ff[s-1].value});
         hue_qb = (hue_t >= {1'b0, stg_ff[s-1].hue_div});

         vld_in[s]          = vld_ff[s-1];
         stg_in[s]          = stg_ff[s-1];
         stg_in[s].sat_rem  = sat_qb ? CHAN_W'(sat_t - {1'b0, stg_ff[s-1].value})
                                     : sat_t[CHAN_W-1:0];
         stg_in[s].sat_bits = {stg_ff[s-1].sat_bits[SAT_W-2:0], 1'b0};
         stg_in[s].sat_q    = {stg_ff[s-1].sat_q[SAT_W-2:0], sat_qb};
         stg_in[s].hue_rem  = hue_qb ? HUE_DIV_W'(hue_t - {1'b0, stg_ff[s-1].hue_div})
                                     : hue_t[HUE_DIV_W-1:0];
         stg_in[s].hue_q    = {stg_ff[s-1].hue_q[HUE_W-2:0], hue_qb};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
      if (advance) begin
         stg_ff <= stg_in;
      end
   end

   // black and grey carry a zero divisor: force hue and saturation to 0
   assign last                  = stg_ff[DIV_STEPS];
   assign rsp_bus.valid         = vld_ff[DIV_STEPS];
   assign rsp_bus.hue           = last.chroma ? last.hue_q : '0;
   assign rsp_bus.saturation    = last.chroma ? last.sat_q : '0;
   assign rsp_bus.value         = last.value;
   assign rsp_bus.hue_undefined = last.undef;

endmodule

>>> hw/rtl/rgb_to_hsv_converter_top.sv
// Path from request accept to result valid: 1 classify register, 1 queue slot,
//   16 divider stages plus entry register.
// Throughput: one request per clock while results are taken, set by the two
//   16-stage pipelined restoring dividers, one quotient bit per stage.
// Reset: synchronous, active high; clears valid flags, queue pointers and queue count only.
module rgb_to_hsv_converter_top (
   input  logic       clock,
   input  logic       reset,
   rhsv_req_if.sink   req_bus,
   rhsv_rsp_if.source rsp_bus
);
   import rhsv_pkg::*;

   // front -> queue: classified request (max, flags, hue offset and divisor, saturation numerator)
   logic          front_valid;
   logic          front_ready;
   rhsv_work_type front_data;

   // queue -> back
   logic          queue_valid;
   logic          queue_ready;
   rhsv_work_type queue_data;

   // Front: max/min, sector pick with red over green over blue, hue offset
   // wrapped into [0, 6*delta), saturation numerator delta*65535.
   rhsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .work_valid (front_valid),
      .work_ready (front_ready),
      .work_data  (front_data)
   );

   // Short queue decouples front from back so each side stalls on its own.
   rhsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_data)
   );

   // Back: saturation = delta*65535/max, hue = x*65536/(6*delta); the whole
   // pipeline holds when the result is not taken.
   rhsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (queue_valid),
      .work_ready (queue_ready),
      .work_data  (queue_data),
      .rsp_bus    (rsp_bus)
   );

   // black pixel reports zeros everywhere
   a_black_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.hue_undefined |->
         rsp_bus.value == '0 && rsp_bus.saturation == '0 && rsp_bus.hue == '0)
      else $error("black pixel with nonzero fields");

   // grey pixel: zero saturation means zero hue
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturation == '0 |-> rsp_bus.hue == '0)
      else $error("zero saturation with nonzero hue");

   // defined hue needs a nonzero value
   a_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hue_undefined |-> rsp_bus.value != '0)
      else $error("defined hue with zero value");

   // front holds its request while the queue is full
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      front_valid && !front_ready |=> front_valid && $stable(front_data))
      else $error("front dropped request while queue full");

endmodule
